FILE: design/cao_pkg.sv
// shared types and constants of the cursor alpha overlay
package cao_pkg;

  // operation codes of an input word
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPOSE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_POINTER_X   = 3'd0;
  localparam logic [2:0] CFG_POINTER_Y   = 3'd1;
  localparam logic [2:0] CFG_HOTSPOT_X   = 3'd2;
  localparam logic [2:0] CFG_HOTSPOT_Y   = 3'd3;
  localparam logic [2:0] CFG_RED_SHIFT   = 3'd4;
  localparam logic [2:0] CFG_GREEN_SHIFT = 3'd5;
  localparam logic [2:0] CFG_BLUE_SHIFT  = 3'd6;

  // queue depths between the parts, powers of two
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // art store geometry
  localparam int STORE_AW = 10;

  // division by 255: (x * 32897) >> 23 is exact for x below 65536
  localparam logic [16:0] RECIP_255  = 17'd32897;
  localparam int          RECIP_SHFT = 23;
  localparam logic [15:0] ROUND_HALF = 16'd127;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  typedef struct packed {
    logic        operation;
    logic [9:0]  art_index;
    logic [31:0] art_color;
    logic [7:0]  art_alpha;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] under_pixel;
  } cao_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [31:0] out_pixel;
  } cao_out_t;

  typedef struct packed {
    logic [11:0] pointer_x;
    logic [11:0] pointer_y;
    logic [4:0]  hotspot_x;
    logic [4:0]  hotspot_y;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } cao_cfg_t;

  // classified compose word handed from front to back
  typedef struct packed {
    logic        hit;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] under_pixel;
    logic [31:0] art_color;
    logic [7:0]  art_alpha;
  } cao_mid_t;

endpackage

FILE: design/cao_queue.sv
// small first-in first-out queue, space guaranteed by the caller's credit count
module cao_queue import cao_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/cao_front.sv
// front part: accepts words, keeps the art store, places the pixel in the art
module cao_front import cao_pkg::*; #(
  parameter int ART_SIZE = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cao_in_t  in_word_i,
  output logic     full_o,
  input  cao_cfg_t cfg_i,
  input  logic     mid_pop_i,
  output logic     mid_push_o,
  output cao_mid_t mid_word_o
);

  localparam logic [11:0] ArtW = 12'(ART_SIZE);
  localparam int          CW   = $clog2(MID_DEPTH + 1);

  logic [39:0]         store_q [2**STORE_AW];
  logic [39:0]         rd_q;
  logic                accept;
  logic                compose;
  logic [11:0]         hot_x, hot_y;
  logic [11:0]         left, top;
  logic [11:0]         dx, dy;
  logic [11:0]         lin;
  logic                hit;
  logic                s1_valid_q;
  logic                s1_hit_q;
  logic [11:0]         s1_x_q, s1_y_q;
  logic [31:0]         s1_under_q;
  logic [CW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(MID_DEPTH));
  assign accept  = push_i && !full_o;
  assign compose = (in_word_i.operation == OP_COMPOSE);

  // art corner, clamped at zero
  assign hot_x = {7'b0, cfg_i.hotspot_x};
  assign hot_y = {7'b0, cfg_i.hotspot_y};
  assign left  = (cfg_i.pointer_x > hot_x) ? cfg_i.pointer_x - hot_x : '0;
  assign top   = (cfg_i.pointer_y > hot_y) ? cfg_i.pointer_y - hot_y : '0;

  // position inside the art and entry number
  assign dx  = in_word_i.pixel_x - left;
  assign dy  = in_word_i.pixel_y - top;
  assign hit = (in_word_i.pixel_x >= left) && (in_word_i.pixel_y >= top) &&
               (dx < ArtW) && (dy < ArtW);
  assign lin = dy * ArtW + dx;

  // art store: load writes, compose reads with registered data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!compose) begin
        store_q[in_word_i.art_index] <= {in_word_i.art_color, in_word_i.art_alpha};
      end else begin
        rd_q <= store_q[lin[STORE_AW-1:0]];
      end
    end
  end

  // compose word in flight beside the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && compose;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && compose) begin
      s1_hit_q   <= hit;
      s1_x_q     <= in_word_i.pixel_x;
      s1_y_q     <= in_word_i.pixel_y;
      s1_under_q <= in_word_i.under_pixel;
    end
  end

  assign mid_push_o            = s1_valid_q;
  assign mid_word_o.hit         = s1_hit_q;
  assign mid_word_o.pixel_x     = s1_x_q;
  assign mid_word_o.pixel_y     = s1_y_q;
  assign mid_word_o.under_pixel = s1_under_q;
  assign mid_word_o.art_color   = rd_q[39:8];
  assign mid_word_o.art_alpha   = rd_q[7:0];

  // credit count: words in flight plus words in the middle queue
  always_comb begin
    cnt_d = cnt_q;
    if ((accept && compose) && !mid_pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!(accept && compose) && mid_pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/cao_back.sv
// back part: blends the art over the pixel underneath in a short pipeline
module cao_back import cao_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cao_cfg_t cfg_i,
  input  logic     mid_empty_i,
  input  cao_mid_t mid_word_i,
  output logic     mid_pop_o,
  input  logic     out_pop_i,
  output logic     out_push_o,
  output cao_out_t out_word_o
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic          issue;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    under_ch [3];
  logic [7:0]    over_ch [3];
  logic [7:0]    inv_a;
  logic [15:0]   sum [3];
  logic [32:0]   prod [3];
  logic [31:0]   blend;

  // stage a registers
  logic          a_valid_q;
  logic          a_we_q, a_full_q;
  logic [11:0]   a_x_q, a_y_q;
  logic [31:0]   a_under_q, a_color_q;
  logic [15:0]   a_sum_q [3];

  // stage b registers
  logic          b_valid_q;
  logic          b_we_q, b_full_q;
  logic [11:0]   b_x_q, b_y_q;
  logic [31:0]   b_under_q, b_color_q;
  logic [7:0]    b_ch_q [3];

  assign issue     = !mid_empty_i && (cnt_q != CW'(OUT_DEPTH));
  assign mid_pop_o = issue;

  // channel extraction and weighted sums
  assign under_ch[0] = 8'(mid_word_i.under_pixel >> cfg_i.red_shift);
  assign under_ch[1] = 8'(mid_word_i.under_pixel >> cfg_i.green_shift);
  assign under_ch[2] = 8'(mid_word_i.under_pixel >> cfg_i.blue_shift);
  assign over_ch[0]  = mid_word_i.art_color[23:16];
  assign over_ch[1]  = mid_word_i.art_color[15:8];
  assign over_ch[2]  = mid_word_i.art_color[7:0];
  assign inv_a       = ALPHA_FULL - mid_word_i.art_alpha;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {8'b0, over_ch[i]} * {8'b0, mid_word_i.art_alpha} +
               {8'b0, under_ch[i]} * {8'b0, inv_a} + ROUND_HALF;
    end
  end

  // divide each sum by 255 through the reciprocal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {17'b0, a_sum_q[i]} * {16'b0, RECIP_255};
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= issue;
      b_valid_q <= a_valid_q;
    end
  end

  // stage a payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_we_q    <= mid_word_i.hit && (mid_word_i.art_alpha != '0);
      a_full_q  <= (mid_word_i.art_alpha == ALPHA_FULL);
      a_x_q     <= mid_word_i.pixel_x;
      a_y_q     <= mid_word_i.pixel_y;
      a_under_q <= mid_word_i.under_pixel;
      a_color_q <= mid_word_i.art_color;
      for (int i = 0; i < 3; i++) begin
        a_sum_q[i] <= sum[i];
      end
    end
  end

  // stage b payload
  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_we_q    <= a_we_q;
      b_full_q  <= a_full_q;
      b_x_q     <= a_x_q;
      b_y_q     <= a_y_q;
      b_under_q <= a_under_q;
      b_color_q <= a_color_q;
      for (int i = 0; i < 3; i++) begin
        b_ch_q[i] <= prod[i][RECIP_SHFT+7:RECIP_SHFT];
      end
    end
  end

  // place channels and pick the result word
  assign blend = ({24'b0, b_ch_q[0]} << cfg_i.red_shift) |
                 ({24'b0, b_ch_q[1]} << cfg_i.green_shift) |
                 ({24'b0, b_ch_q[2]} << cfg_i.blue_shift);

  assign out_push_o              = b_valid_q;
  assign out_word_o.write_enable = b_we_q;
  assign out_word_o.out_x        = b_x_q;
  assign out_word_o.out_y        = b_y_q;
  assign out_word_o.out_pixel    = !b_we_q ? b_under_q :
                                   (b_full_q ? b_color_q : blend);

  // credit count: words in the pipeline plus words in the result queue
  always_comb begin
    cnt_d = cnt_q;
    if (issue && !out_pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!issue && out_pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/cursor_alpha_overlay.sv
// cursor overlay: each accepted compose word gives one result word on the result side
// sustained rate one word per cycle while full is low; the art store read, the middle
// queue, a two-stage blend and the result queue set latency; load words give no result
// reset: config registers to defaults, queues empty, full and empty settle at once
// the art store is not cleared by reset; entries hold nothing until loaded
module cursor_alpha_overlay import cao_pkg::*; #(
  parameter int ART_SIZE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  cao_in_t    in_word_i,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output cao_out_t   out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  cao_cfg_t cfg_q;
  logic     mid_push, mid_pop, mid_empty;
  cao_mid_t mid_wr, mid_rd;
  logic     out_push, out_pop;
  cao_out_t out_wr;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pointer_x   <= 12'd0;
      cfg_q.pointer_y   <= 12'd0;
      cfg_q.hotspot_x   <= 5'd2;
      cfg_q.hotspot_y   <= 5'd2;
      cfg_q.red_shift   <= 5'd16;
      cfg_q.green_shift <= 5'd8;
      cfg_q.blue_shift  <= 5'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINTER_X:   cfg_q.pointer_x   <= cfg_data_i;
        CFG_POINTER_Y:   cfg_q.pointer_y   <= cfg_data_i;
        CFG_HOTSPOT_X:   cfg_q.hotspot_x   <= cfg_data_i[4:0];
        CFG_HOTSPOT_Y:   cfg_q.hotspot_y   <= cfg_data_i[4:0];
        CFG_RED_SHIFT:   cfg_q.red_shift   <= cfg_data_i[4:0];
        CFG_GREEN_SHIFT: cfg_q.green_shift <= cfg_data_i[4:0];
        CFG_BLUE_SHIFT:  cfg_q.blue_shift  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  cao_front #(
    .ART_SIZE (ART_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .cfg_i      (cfg_q),
    .mid_pop_i  (mid_pop),
    .mid_push_o (mid_push),
    .mid_word_o (mid_wr)
  );

  cao_queue #(
    .WIDTH ($bits(cao_mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wr),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .empty_o (mid_empty)
  );

  cao_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_rd),
    .mid_pop_o   (mid_pop),
    .out_pop_i   (out_pop),
    .out_push_o  (out_push),
    .out_word_o  (out_wr)
  );

  assign out_pop = pop && !empty;

  cao_queue #(
    .WIDTH ($bits(cao_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wr),
    .pop_i   (out_pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule
